FILE: src/adsr_pkg.sv
`default_nettype none

package adsr_pkg;

   // Position counter width
   localparam int POS_BITS = 20;

   // Field widths
   localparam int SAMPLE_W   = 16;
   localparam int LEN_W      = 20;
   localparam int GAIN_W     = 16;
   localparam int GAIN_FRAC  = 15;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;

   // Unity gain in Q1.15, one bit wider than the gain field
   localparam logic [GAIN_W:0] UNITY = 17'h08000;

   // Compare width: holds position, length and attack+decay without overflow
   localparam int CMP_W = ((POS_BITS > LEN_W + 1) ? POS_BITS : LEN_W + 1) + 1;

   // Shared multiplier and serial divider
   localparam int MUL_A_W   = LEN_W;
   localparam int MUL_B_W   = GAIN_W + 1;
   localparam int PROD_W    = MUL_A_W + MUL_B_W;
   localparam int QUOT_W    = GAIN_W;
   localparam int DEN_W     = LEN_W;
   localparam int NUM_W     = DEN_W + QUOT_W;
   localparam int DIV_CNT_W = $clog2(QUOT_W);

   // Microcode store
   localparam int PC_W = 4;

   localparam logic [PC_W-1:0] PC_FETCH  = 4'd0;
   localparam logic [PC_W-1:0] PC_CLASS  = 4'd1;
   localparam logic [PC_W-1:0] PC_TZERO  = 4'd2;
   localparam logic [PC_W-1:0] PC_TSUS   = 4'd3;
   localparam logic [PC_W-1:0] PC_TATT   = 4'd4;
   localparam logic [PC_W-1:0] PC_MULENV = 4'd5;
   localparam logic [PC_W-1:0] PC_DIVLD  = 4'd6;
   localparam logic [PC_W-1:0] PC_DIVSTP = 4'd7;
   localparam logic [PC_W-1:0] PC_GQUOT  = 4'd8;
   localparam logic [PC_W-1:0] PC_GZERO  = 4'd9;
   localparam logic [PC_W-1:0] PC_GSUS   = 4'd10;
   localparam logic [PC_W-1:0] PC_SCALE  = 4'd11;
   localparam logic [PC_W-1:0] PC_EMIT   = 4'd12;
   localparam logic [PC_W-1:0] PC_REEMIT = 4'd13;

   // Register map
   typedef enum logic [1:0] {
      REG_ATTACK  = 2'd0,
      REG_DECAY   = 2'd1,
      REG_SUSTAIN = 2'd2,
      REG_RELEASE = 2'd3
   } reg_index_type;

   typedef enum logic [0:0] {
      MS_ENV = 1'b0,
      MS_OUT = 1'b1
   } mul_sel_type;

   typedef enum logic [1:0] {
      GS_QUOT = 2'd0,
      GS_ZERO = 2'd1,
      GS_SUS  = 2'd2
   } gain_sel_type;

   typedef enum logic [3:0] {
      JC_NEVER    = 4'd0,
      JC_ALWAYS   = 4'd1,
      JC_NO_REQ   = 4'd2,
      JC_ZERO     = 4'd3,
      JC_SUS      = 4'd4,
      JC_ATT      = 4'd5,
      JC_DIV_BUSY = 4'd6,
      JC_OUT_FREE = 4'd7
   } jump_type;

   // One control word of the program
   typedef struct packed {
      logic              ld_item;
      logic              classify;
      logic              mul_en;
      mul_sel_type       msel;
      logic              div_load;
      logic              div_step;
      logic              gain_ld;
      gain_sel_type      gsel;
      logic              emit;
      jump_type          jc;
      logic [PC_W-1:0]   target;
   } uword_type;

   // Datapath flags tested by jumps
   typedef struct packed {
      logic no_req;
      logic zero;
      logic sus;
      logic att;
      logic div_busy;
      logic out_busy;
   } status_type;

   typedef struct packed {
      logic [LEN_W-1:0]  attack_len;
      logic [LEN_W-1:0]  decay_len;
      logic [GAIN_W-1:0] sustain_level;
      logic [LEN_W-1:0]  release_len;
   } cfg_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample_in;
      logic [LEN_W-1:0]           note_length;
      logic                       note_start;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample_out;
      logic [GAIN_W-1:0]          gain_level;
      logic                       note_end;
   } rsp_type;

endpackage

`default_nettype wire

FILE: src/adsr_csr.sv
`default_nettype none

module adsr_csr (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   psel,
   input  wire                                   penable,
   input  wire                                   pwrite,
   input  wire  [adsr_pkg::CSR_ADDR_W-1:0]       paddr,
   input  wire  [adsr_pkg::CSR_DATA_W-1:0]       pwdata,
   output logic [adsr_pkg::CSR_DATA_W-1:0]       prdata,
   output logic                                  pready,
   output adsr_pkg::cfg_type                     cfg
);
   import adsr_pkg::*;

   cfg_type       cfg_ff, cfg_in;
   reg_index_type idx;
   logic          wr_en;

   assign idx   = reg_index_type'(paddr[CSR_ADDR_W-1:2]);
   assign wr_en = psel & penable & pwrite;
   assign pready = 1'b1;
   assign cfg   = cfg_ff;

   // Write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            REG_ATTACK:  cfg_in.attack_len    = pwdata[LEN_W-1:0];
            REG_DECAY:   cfg_in.decay_len     = pwdata[LEN_W-1:0];
            REG_SUSTAIN: cfg_in.sustain_level = pwdata[GAIN_W-1:0];
            REG_RELEASE: cfg_in.release_len   = pwdata[LEN_W-1:0];
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.attack_len    <= '0;
         cfg_ff.decay_len     <= '0;
         cfg_ff.sustain_level <= UNITY[GAIN_W-1:0];
         cfg_ff.release_len   <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read back
   always_comb begin
      case (idx)
         REG_ATTACK:  prdata = CSR_DATA_W'(cfg_ff.attack_len);
         REG_DECAY:   prdata = CSR_DATA_W'(cfg_ff.decay_len);
         REG_SUSTAIN: prdata = CSR_DATA_W'(cfg_ff.sustain_level);
         REG_RELEASE: prdata = CSR_DATA_W'(cfg_ff.release_len);
         default:     prdata = '0;
      endcase
   end

endmodule

`default_nettype wire

FILE: src/adsr_seq.sv
`default_nettype none

module adsr_seq (
   input  wire                     clock,
   input  wire                     reset,
   input  adsr_pkg::status_type    status,
   output adsr_pkg::uword_type     ucw
);
   import adsr_pkg::*;

   logic [PC_W-1:0] pc_ff, pc_in;
   logic            take;

   // Program store
   function automatic uword_type ucode(input logic [PC_W-1:0] pc);
      uword_type w;
      w        = '0;
      w.jc     = JC_NEVER;
      w.target = PC_FETCH;
      case (pc)
         PC_FETCH: begin
            w.ld_item = 1'b1;
            w.jc      = JC_NO_REQ;
            w.target  = PC_FETCH;
         end
         PC_CLASS: begin
            w.classify = 1'b1;
         end
         PC_TZERO: begin
            w.jc     = JC_ZERO;
            w.target = PC_GZERO;
         end
         PC_TSUS: begin
            w.jc     = JC_SUS;
            w.target = PC_GSUS;
         end
         PC_TATT: begin
            w.jc     = JC_ATT;
            w.target = PC_DIVLD;
         end
         PC_MULENV: begin
            w.mul_en = 1'b1;
            w.msel   = MS_ENV;
         end
         PC_DIVLD: begin
            w.div_load = 1'b1;
         end
         PC_DIVSTP: begin
            w.div_step = 1'b1;
            w.jc       = JC_DIV_BUSY;
            w.target   = PC_DIVSTP;
         end
         PC_GQUOT: begin
            w.gain_ld = 1'b1;
            w.gsel    = GS_QUOT;
            w.jc      = JC_ALWAYS;
            w.target  = PC_SCALE;
         end
         PC_GZERO: begin
            w.gain_ld = 1'b1;
            w.gsel    = GS_ZERO;
            w.jc      = JC_ALWAYS;
            w.target  = PC_SCALE;
         end
         PC_GSUS: begin
            w.gain_ld = 1'b1;
            w.gsel    = GS_SUS;
         end
         PC_SCALE: begin
            w.mul_en = 1'b1;
            w.msel   = MS_OUT;
         end
         PC_EMIT: begin
            w.emit   = 1'b1;
            w.jc     = JC_OUT_FREE;
            w.target = PC_FETCH;
         end
         PC_REEMIT: begin
            w.jc     = JC_ALWAYS;
            w.target = PC_EMIT;
         end
         default: begin
            w.jc     = JC_ALWAYS;
            w.target = PC_FETCH;
         end
      endcase
      return w;
   endfunction

   assign ucw = ucode(pc_ff);

   // Jump condition
   always_comb begin
      case (ucw.jc)
         JC_NEVER:    take = 1'b0;
         JC_ALWAYS:   take = 1'b1;
         JC_NO_REQ:   take = status.no_req;
         JC_ZERO:     take = status.zero;
         JC_SUS:      take = status.sus;
         JC_ATT:      take = status.att;
         JC_DIV_BUSY: take = status.div_busy;
         JC_OUT_FREE: take = ~status.out_busy;
         default:     take = 1'b1;
      endcase
   end

   assign pc_in = take ? ucw.target : pc_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= PC_FETCH;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

`default_nettype wire

FILE: src/adsr_div.sv
`default_nettype none

module adsr_div (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 load,
   input  wire                                 step,
   input  wire  [adsr_pkg::NUM_W-1:0]          num,
   input  wire  [adsr_pkg::DEN_W-1:0]          den,
   output logic [adsr_pkg::QUOT_W-1:0]         quot,
   output logic                                busy
);
   import adsr_pkg::*;

   logic [DEN_W-1:0]     rem_ff, rem_in;
   logic [QUOT_W-1:0]    low_ff, low_in;
   logic [QUOT_W-1:0]    quot_ff, quot_in;
   logic [DEN_W-1:0]     den_ff, den_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DEN_W:0]       trial;
   logic [DEN_W:0]       diff;
   logic                 ge;

   // One restoring step: quotient is known to fit QUOT_W bits
   assign trial = {rem_ff, low_ff[QUOT_W-1]};
   assign ge    = trial >= {1'b0, den_ff};
   assign diff  = trial - {1'b0, den_ff};

   always_comb begin
      rem_in  = rem_ff;
      low_in  = low_ff;
      quot_in = quot_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      if (load) begin
         rem_in  = num[NUM_W-1:QUOT_W];
         low_in  = num[QUOT_W-1:0];
         den_in  = den;
         cnt_in  = '0;
      end else if (step) begin
         rem_in  = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         low_in  = {low_ff[QUOT_W-2:0], 1'b0};
         quot_in = {quot_ff[QUOT_W-2:0], ge};
         cnt_in  = cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      low_ff  <= low_in;
      quot_ff <= quot_in;
      den_ff  <= den_in;
   end

   assign quot = quot_ff;
   assign busy = cnt_ff != DIV_CNT_W'(QUOT_W - 1);

endmodule

`default_nettype wire

FILE: src/adsr_dpath.sv
`default_nettype none

module adsr_dpath (
   input  wire                      clock,
   input  wire                      reset,
   input  adsr_pkg::uword_type      ucw,
   output adsr_pkg::status_type     status,
   input  adsr_pkg::cfg_type        cfg,
   input  wire                      req_valid,
   input  adsr_pkg::req_type        req_data,
   output logic                     rsp_valid,
   input  wire                      rsp_ready,
   output adsr_pkg::rsp_type        rsp_data
);
   import adsr_pkg::*;

   // Item registers
   logic [SAMPLE_W:0]     mag_ff, mag_in;
   logic                  neg_ff;
   logic [LEN_W-1:0]      len_ff;
   logic [POS_BITS-1:0]   pos_ff;

   // Envelope state
   logic [POS_BITS-1:0]   note_pos_ff, note_pos_in;
   logic [GAIN_W-1:0]     last_gain_ff, last_gain_in;

   // Phase flags
   logic zero_ff, sus_ff, att_ff, dec_ff, hold_ff, end_ff;

   // Operands and results
   logic [MUL_A_W-1:0]    opa_ff, opa_in;
   logic [MUL_B_W-1:0]    opb_ff, opb_in;
   logic [PROD_W-1:0]     prod_ff;
   logic [MUL_A_W-1:0]    mul_a;
   logic [MUL_B_W-1:0]    mul_b;
   logic [GAIN_W-1:0]     gain_ff, gain_in;
   logic [GAIN_W:0]       dec_gain;

   // Output register
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff;

   logic                  accept, out_busy, fire;
   logic [CMP_W-1:0]      pos_x, len_x, att_x, dec_x, rel_x, ad_x;
   logic                  rel_win, past_end, in_att, in_dec;
   logic [GAIN_W-1:0]     sus_c;
   logic [NUM_W-1:0]      div_num;
   logic [DEN_W-1:0]      div_den;
   logic [QUOT_W-1:0]     quot;
   logic                  div_busy;
   logic [SAMPLE_W-1:0]   scaled;

   assign accept   = req_valid & ucw.ld_item;
   assign out_busy = rsp_valid_ff & ~rsp_ready;
   assign fire     = ucw.emit & ~out_busy;

   // Magnitude of the incoming sample
   assign mag_in = req_data.sample_in[SAMPLE_W-1]
                   ? (17'h10000 - {1'b0, req_data.sample_in})
                   : {1'b0, req_data.sample_in};

   always_ff @(posedge clock) begin
      if (accept) begin
         mag_ff <= mag_in;
         neg_ff <= req_data.sample_in[SAMPLE_W-1];
         len_ff <= req_data.note_length;
         pos_ff <= req_data.note_start ? '0 : note_pos_ff;
      end
   end

   // Phase classification
   assign sus_c = (cfg.sustain_level > UNITY[GAIN_W-1:0])
                  ? UNITY[GAIN_W-1:0] : cfg.sustain_level;
   assign pos_x = CMP_W'(pos_ff);
   assign len_x = CMP_W'(len_ff);
   assign att_x = CMP_W'(cfg.attack_len);
   assign dec_x = CMP_W'(cfg.decay_len);
   assign rel_x = CMP_W'(cfg.release_len);
   assign ad_x  = att_x + dec_x;

   assign rel_win  = (rel_x <= len_x) && (pos_x > len_x - rel_x);
   assign past_end = (pos_x >= len_x) || (rel_x == '0);
   assign in_att   = pos_x < att_x;
   assign in_dec   = pos_x < ad_x;

   always_comb begin
      if (rel_win) begin
         opa_in = MUL_A_W'(len_x - pos_x);
         opb_in = {1'b0, last_gain_ff};
      end else begin
         opa_in = MUL_A_W'(pos_x - att_x);
         opb_in = UNITY - {1'b0, sus_c};
      end
   end

   always_ff @(posedge clock) begin
      if (ucw.classify) begin
         zero_ff <= rel_win & past_end;
         hold_ff <= rel_win;
         att_ff  <= ~rel_win & in_att;
         dec_ff  <= ~rel_win & ~in_att & in_dec;
         sus_ff  <= ~rel_win & ~in_att & ~in_dec;
         end_ff  <= (pos_x + 1'b1) == len_x;
         opa_ff  <= opa_in;
         opb_ff  <= opb_in;
      end
   end

   // Shared multiplier
   always_comb begin
      case (ucw.msel)
         MS_ENV: begin
            mul_a = opa_ff;
            mul_b = opb_ff;
         end
         MS_OUT: begin
            mul_a = MUL_A_W'(mag_ff);
            mul_b = {1'b0, gain_ff};
         end
         default: begin
            mul_a = opa_ff;
            mul_b = opb_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (ucw.mul_en) begin
         prod_ff <= mul_a * mul_b;
      end
   end

   // Divider operands: attack divides pos << 15, others the product
   assign div_num = att_ff
      ? {{(NUM_W - LEN_W - GAIN_FRAC){1'b0}}, pos_x[LEN_W-1:0], {GAIN_FRAC{1'b0}}}
      : prod_ff[NUM_W-1:0];
   assign div_den = att_ff ? cfg.attack_len
                  : dec_ff ? cfg.decay_len
                  : cfg.release_len;

   adsr_div u_div (
      .clock (clock),
      .reset (reset),
      .load  (ucw.div_load),
      .step  (ucw.div_step),
      .num   (div_num),
      .den   (div_den),
      .quot  (quot),
      .busy  (div_busy)
   );

   // Gain select
   assign dec_gain = UNITY - {1'b0, quot};

   always_comb begin
      gain_in = gain_ff;
      if (ucw.gain_ld) begin
         case (ucw.gsel)
            GS_QUOT: gain_in = dec_ff ? dec_gain[GAIN_W-1:0] : quot;
            GS_ZERO: gain_in = '0;
            GS_SUS:  gain_in = sus_c;
            default: gain_in = gain_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      gain_ff <= gain_in;
   end

   // Scaled sample, truncated toward zero
   assign scaled = prod_ff[GAIN_FRAC +: SAMPLE_W];

   // State update on result transfer
   assign note_pos_in  = fire ? pos_ff + 1'b1 : note_pos_ff;
   assign last_gain_in = (fire && !hold_ff) ? gain_ff : last_gain_ff;
   assign rsp_valid_in = fire | out_busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         note_pos_ff  <= '0;
         last_gain_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         note_pos_ff  <= note_pos_in;
         last_gain_ff <= last_gain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_data_ff.sample_out <= neg_ff ? (SAMPLE_W'(0) - scaled) : scaled;
         rsp_data_ff.gain_level <= gain_ff;
         rsp_data_ff.note_end   <= end_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign status.no_req   = ~req_valid;
   assign status.zero     = zero_ff;
   assign status.sus      = sus_ff;
   assign status.att      = att_ff;
   assign status.div_busy = div_busy;
   assign status.out_busy = out_busy;

endmodule

`default_nettype wire

FILE: src/adsr_envelope_shaper.sv
// Channel  Direction  Handshake                     Payload
// req      in         req_valid / req_ready         req_data  (sample, note length, start)
// rsp      out        rsp_valid / rsp_ready         rsp_data  (sample, gain, note end)
// csr      in/out     psel, penable, pwrite, pready paddr, pwdata, prdata
//
// One item at a time. The gain is zero, the sustain level, or a quotient; in
// attack the multiply step is skipped. The quotient comes from the
// one-bit-per-cycle divider loop of the microcode.
// Reset is synchronous; it clears position, last gain, output valid and the
// program counter, and loads the register defaults.
// A stalled result holds in the output register; the next item is taken
// while it waits and finishes up to the transfer step.
`default_nettype none

module adsr_envelope_shaper (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_valid,
   output logic                                  req_ready,
   input  adsr_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   input  wire                                   rsp_ready,
   output adsr_pkg::rsp_type                     rsp_data,
   input  wire                                   psel,
   input  wire                                   penable,
   input  wire                                   pwrite,
   input  wire  [adsr_pkg::CSR_ADDR_W-1:0]       paddr,
   input  wire  [adsr_pkg::CSR_DATA_W-1:0]       pwdata,
   output logic [adsr_pkg::CSR_DATA_W-1:0]       prdata,
   output logic                                  pready
);
   import adsr_pkg::*;

   cfg_type    cfg;
   uword_type  ucw;
   status_type status;

   adsr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   adsr_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ucw    (ucw)
   );

   adsr_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .ucw       (ucw),
      .status    (status),
      .cfg       (cfg),
      .req_valid (req_valid),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // Input transfer only in the fetch step
   assign req_ready = ucw.ld_item;

endmodule

`default_nettype wire
